>>> design/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants for the feedback comb echo block: transaction
// payload structs, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package efc_pkg;

	// Default depth of the delay store, in samples
	localparam int unsigned STORE_DEPTH_DEF = 65536;

	// Field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LEN_W    = 17;
	localparam int unsigned GAIN_W   = 15;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 17;

	localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_GAIN   = 2'd1;

	// Register reset values (gain 0.5 in Q0.15)
	localparam logic [LEN_W-1:0]  DELAY_LENGTH_RESET = 17'd22050;
	localparam logic [GAIN_W-1:0] DECAY_GAIN_RESET   = 15'd16384;

	// Saturation limits of Q1.15
	localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 18'sd32767;
	localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -18'sd32768;

	// Input transaction
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       end_of_block;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_of_block;
	} out_item_t;

endpackage

>>> design/echo_feedback_comb.sv
// ----------------------------------------------------------------------------
// echo_feedback_comb
// Feedback comb echo on Q1.15 samples: out = sat(in + gain * store[ptr]),
// written back to the store at the same entry; circular pointer.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output side keeps up, and returns one
// result per sample; stage 1 and the input stall while a result waits and
// out_ready is low. The sample enters stage 1 while its store read is in
// flight; the result is registered when stage 1 advances and is taken at the
// next edge with out_ready high. The delay store does one read at acceptance
// and one write when the result is registered; the previous sample's result is
// forwarded when it targets the same entry. No clearing pass is needed after
// reset: the pointer only ever walks up from zero, so the written entries
// always form a prefix of the store, tracked by a fill count, and entries
// above it read as zero. delay_length of zero acts as one, values above
// STORE_DEPTH act as STORE_DEPTH; if the pointer lies beyond a shortened
// length it restarts at zero. Writes to unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module echo_feedback_comb #(
	parameter int unsigned STORE_DEPTH = efc_pkg::STORE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input samples
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  efc_pkg::in_item_t                      in_data,
	// results
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output efc_pkg::out_item_t                     out_data,
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [efc_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [efc_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam int unsigned LW = (AW + 1 > efc_pkg::LEN_W) ? AW + 1 : efc_pkg::LEN_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);
	localparam logic [AW:0]   DEPTH_F = (AW+1)'(STORE_DEPTH);

	// Configuration registers
	logic [efc_pkg::LEN_W-1:0]  delay_length_q;
	logic [efc_pkg::GAIN_W-1:0] decay_gain_q;

	// Pointer, fill count and last-write forwarding
	logic [AW-1:0] ptr_q;
	logic [AW:0]   fill_q;
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic signed [efc_pkg::SAMPLE_W-1:0] wr_data_q;

	// Stage 1 (store read in flight)
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic signed [efc_pkg::SAMPLE_W-1:0] sample_s1;
	logic          eob_s1;

	// Output register
	logic               out_valid_q;
	efc_pkg::out_item_t out_data_q;

	// Handshake
	logic in_acc;
	logic s1_adv;

	// Pointer math
	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] ptr_ext;
	logic [LW-1:0] addr_ext;
	logic [LW-1:0] nxt_ext;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] ptr_d;

	// Datapath
	logic signed [efc_pkg::SAMPLE_W-1:0] rdata;
	logic signed [efc_pkg::SAMPLE_W-1:0] entry;
	logic signed [31:0]                  prod;
	logic signed [31:0]                  prod_rnd;
	logic signed [efc_pkg::SAMPLE_W:0]   prod_q15;
	logic signed [efc_pkg::SAMPLE_W+1:0] sum_wide;
	logic signed [efc_pkg::SAMPLE_W-1:0] sum_sat;

	// Handshake: output register decouples the two sides
	assign cfg_ready = 1'b1;
	assign s1_adv    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Effective length and pointer for the incoming sample
	always_comb begin
		len_ext = LW'(delay_length_q);
		if (len_ext == '0) begin
			len_eff = LW'(1);
		end else if (len_ext > DEPTH_L) begin
			len_eff = DEPTH_L;
		end else begin
			len_eff = len_ext;
		end
		ptr_ext  = LW'(ptr_q);
		addr_ext = (ptr_ext >= len_eff) ? '0 : ptr_ext;
		rd_addr  = addr_ext[AW-1:0];
		nxt_ext  = addr_ext + LW'(1);
		ptr_d    = (nxt_ext >= len_eff) ? '0 : nxt_ext[AW-1:0];
	end

	// Entry select: last write, stored value, or zero above the fill count
	always_comb begin
		if (wr_vld_q && (wr_addr_q == addr_s1)) begin
			entry = wr_data_q;
		end else if ({1'b0, addr_s1} < fill_q) begin
			entry = rdata;
		end else begin
			entry = '0;
		end
	end

	// Multiply, round half up to Q1.15, add and saturate
	always_comb begin
		prod     = 32'(entry) * $signed({17'd0, decay_gain_q});
		prod_rnd = prod + 32'sd16384;
		prod_q15 = prod_rnd[31:15];
		sum_wide = 18'(sample_s1) + 18'(prod_q15);
		if (sum_wide > efc_pkg::SAT_MAX) begin
			sum_sat = efc_pkg::SAMPLE_W'(efc_pkg::SAT_MAX);
		end else if (sum_wide < efc_pkg::SAT_MIN) begin
			sum_sat = efc_pkg::SAMPLE_W'(efc_pkg::SAT_MIN);
		end else begin
			sum_sat = sum_wide[efc_pkg::SAMPLE_W-1:0];
		end
	end

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= efc_pkg::DELAY_LENGTH_RESET;
			decay_gain_q   <= efc_pkg::DECAY_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				efc_pkg::CFG_DELAY_LENGTH: delay_length_q <= cfg_data[efc_pkg::LEN_W-1:0];
				efc_pkg::CFG_DECAY_GAIN:   decay_gain_q   <= cfg_data[efc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			fill_q      <= '0;
			wr_vld_q    <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				ptr_q <= ptr_d;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_adv) begin
				wr_vld_q    <= 1'b1;
				out_valid_q <= 1'b1;
				if ({1'b0, addr_s1} == fill_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1   <= rd_addr;
			sample_s1 <= in_data.sample_in;
			eob_s1    <= in_data.end_of_block;
		end
		if (s1_adv) begin
			wr_addr_q                <= addr_s1;
			wr_data_q                <= sum_sat;
			out_data_q.sample_out    <= sum_sat;
			out_data_q.last_of_block <= eob_s1;
		end
	end

	// Delay store
	efc_delay_mem #(
		.DEPTH (STORE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (sum_sat),
		.re    (in_acc),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill count beyond store depth");

	// Writes stay within the written prefix plus one
	a_write_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> ({1'b0, addr_s1} <= fill_q))
		else $error("store write outside the filled prefix");

	// Pointer stays inside the store
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ptr_q} < DEPTH_F)
		else $error("write pointer outside the store");

	// A sample leaving stage 1 always lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("result lost between stage 1 and output");

	// A stalled stage 1 keeps its address
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(addr_s1)))
		else $error("stage 1 changed while stalled");

endmodule

>>> design/efc_delay_mem.sv
// ----------------------------------------------------------------------------
// efc_delay_mem
// Delay store: one write port and one read port, read data registered.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module efc_delay_mem #(
	parameter int unsigned DEPTH = efc_pkg::STORE_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [efc_pkg::SAMPLE_W-1:0] wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [efc_pkg::SAMPLE_W-1:0] rdata
);

	logic signed [efc_pkg::SAMPLE_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
